>>> design/phe_pkg.sv
package phe_pkg;

	localparam int PROGRAM_DEPTH  = 64;
	localparam int WORK_REGISTERS = 5;
	localparam int RESULT_REG     = 2;
	localparam int QUEUE_DEPTH    = 2;

	localparam int DATA_W   = 64;
	localparam int HALF_W   = DATA_W / 2;
	localparam int CTRL_W   = 16;
	localparam int LEN_W    = 7;
	localparam int SLOT_W   = 6;
	localparam int OPC_W    = 3;
	localparam int REGF_W   = 3;
	localparam int SHIFT_W  = 6;
	localparam int INST_W   = CTRL_W + DATA_W;
	localparam int IDX_W    = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
	localparam int PC_W     = $clog2(PROGRAM_DEPTH + 1);
	localparam int RIDX_W   = $clog2(WORK_REGISTERS);
	localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	// Bit positions inside a stored control word.
	localparam int CTRL_OPC_LSB   = 0;
	localparam int CTRL_DEST_LSB  = 3;
	localparam int CTRL_CONST_BIT = 6;
	localparam int CTRL_SRC_LSB   = 7;
	localparam int CTRL_SHIFT_LSB = 10;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	typedef enum logic [OPC_W-1:0] {
		OP_MOV,
		OP_ADD,
		OP_MUL,
		OP_XOR,
		OP_SHL,
		OP_SHR,
		OP_ROTL,
		OP_ROTR
	} opcode_t;

	typedef enum logic {
		ITEM_WRITE,
		ITEM_EVAL
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_EXEC,
		ST_MUL,
		ST_MULWB,
		ST_DONE,
		ST_OUT
	} back_state_t;

	// One queued item: data0 carries the immediate of a write or the key of an evaluation.
	typedef struct packed {
		item_kind_t        kind;
		logic [IDX_W-1:0]  slot;
		logic [CTRL_W-1:0] ctrl;
		logic [DATA_W-1:0] data0;
		logic [DATA_W-1:0] data1;
	} phe_item_t;

	// Folds a register field into the working set by at most two subtractions.
	function automatic logic [RIDX_W-1:0] reduce_reg(input logic [REGF_W-1:0] v);
		logic [REGF_W:0] t;
		t = {1'b0, v};
		if (t >= (REGF_W+1)'(WORK_REGISTERS)) t = t - (REGF_W+1)'(WORK_REGISTERS);
		if (t >= (REGF_W+1)'(WORK_REGISTERS)) t = t - (REGF_W+1)'(WORK_REGISTERS);
		return RIDX_W'(t);
	endfunction

endpackage

>>> design/programmable_hash_evaluator.sv
// Runs a stored program of up to 64 instructions over five 64-bit working registers
// and returns register 2 as the hash. Items enter through start/busy into a two-entry
// queue; busy is high only while that queue is full. A write item is stored into the
// program as it leaves the queue. An evaluation latches its key, seed and the program
// length as it leaves the queue; each instruction then passes through a
// register-file read state and an execute state, and each multiply also through
// three passes of the single 32x32 multiplier and a write-back state.
// The result appears on hash_value with done high for exactly one cycle and
// must be taken then; the receiver cannot stall it. Write program_length only while no
// evaluation is queued or running.
module programmable_hash_evaluator import phe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [SLOT_W-1:0]   slot_index,
	input  logic [OPC_W-1:0]    opcode,
	input  logic [REGF_W-1:0]   dest_register,
	input  logic                source_is_constant,
	input  logic [REGF_W-1:0]   source_register,
	input  logic [SHIFT_W-1:0]  shift_amount,
	input  logic [DATA_W-1:0]   immediate_constant,
	input  logic [DATA_W-1:0]   hash_key,
	input  logic [DATA_W-1:0]   hash_seed,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEN_W-1:0]    cfg_data,
	output logic                done,
	output logic [DATA_W-1:0]   hash_value
);

	logic      queue_full;
	logic      push;
	phe_item_t push_item;
	logic      pop;
	phe_item_t head;
	logic      head_valid;

	assign cfg_ready = 1'b1;

	phe_front u_front (
		.start              (start),
		.busy               (busy),
		.cmd                (cmd),
		.slot_index         (slot_index),
		.opcode             (opcode),
		.dest_register      (dest_register),
		.source_is_constant (source_is_constant),
		.source_register    (source_register),
		.shift_amount       (shift_amount),
		.immediate_constant (immediate_constant),
		.hash_key           (hash_key),
		.hash_seed          (hash_seed),
		.queue_full         (queue_full),
		.push               (push),
		.push_item          (push_item)
	);

	phe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	phe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.hash_value (hash_value)
	);

endmodule

>>> design/phe_front.sv
module phe_front import phe_pkg::*; (
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [SLOT_W-1:0]   slot_index,
	input  logic [OPC_W-1:0]    opcode,
	input  logic [REGF_W-1:0]   dest_register,
	input  logic                source_is_constant,
	input  logic [REGF_W-1:0]   source_register,
	input  logic [SHIFT_W-1:0]  shift_amount,
	input  logic [DATA_W-1:0]   immediate_constant,
	input  logic [DATA_W-1:0]   hash_key,
	input  logic [DATA_W-1:0]   hash_seed,
	input  logic                queue_full,
	output logic                push,
	output phe_item_t           push_item
);

	logic is_eval;
	logic slot_ok;

	assign is_eval = (cmd == CMD_EVAL);
	assign slot_ok = (32'(slot_index) < 32'(PROGRAM_DEPTH));
	assign busy    = queue_full;

	// A write to a slot beyond the store is taken but never queued.
	assign push = start && !queue_full && (is_eval || slot_ok);

	always_comb begin
		push_item.kind = is_eval ? ITEM_EVAL : ITEM_WRITE;
		push_item.slot = IDX_W'(slot_index);
		push_item.ctrl = '0;
		push_item.ctrl[CTRL_OPC_LSB +: OPC_W]     = opcode;
		push_item.ctrl[CTRL_DEST_LSB +: REGF_W]   = REGF_W'(reduce_reg(dest_register));
		push_item.ctrl[CTRL_CONST_BIT]            = source_is_constant;
		push_item.ctrl[CTRL_SRC_LSB +: REGF_W]    = REGF_W'(reduce_reg(source_register));
		push_item.ctrl[CTRL_SHIFT_LSB +: SHIFT_W] = shift_amount;
		push_item.data0 = is_eval ? hash_key : immediate_constant;
		push_item.data1 = hash_seed;
	end

endmodule

>>> design/phe_fifo.sv
module phe_fifo import phe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  phe_item_t push_item,
	output logic      full,
	input  logic      pop,
	output phe_item_t head,
	output logic      head_valid
);

	phe_item_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/phe_back.sv
module phe_back import phe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  phe_item_t         head,
	input  logic              head_valid,
	output logic              pop,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_data,
	output logic              done,
	output logic [DATA_W-1:0] hash_value
);

	logic [INST_W-1:0]         imem [PROGRAM_DEPTH];
	logic [INST_W-1:0]         inst_q;
	logic [IDX_W-1:0]          imem_raddr;
	logic                      imem_we;

	logic [DATA_W-1:0]         rf [WORK_REGISTERS];
	logic [WORK_REGISTERS-1:0] rf_valid_q;
	logic [RIDX_W-1:0]         rf_addr_a;
	logic                      rf_we;
	logic [DATA_W-1:0]         rf_wdata;
	logic [DATA_W-1:0]         rda_q;
	logic [DATA_W-1:0]         rdb_q;

	logic [DATA_W-1:0]         key_q;
	logic [DATA_W-1:0]         seed_q;
	logic [LEN_W-1:0]          prog_len_q;
	logic [PC_W-1:0]           len_q;
	logic [PC_W-1:0]           pc_q;
	logic [PC_W-1:0]           pc_inc;
	logic                      last;

	logic [DATA_W-1:0]         opa_q;
	logic [DATA_W-1:0]         opb_q;
	logic [DATA_W-1:0]         prod_q;
	logic [DATA_W-1:0]         acc_q;
	logic [1:0]                mcnt_q;
	logic [HALF_W-1:0]         mul_a;
	logic [HALF_W-1:0]         mul_b;
	logic [DATA_W-1:0]         mul_res;

	back_state_t               state_q;
	back_state_t               state_d;
	logic                      eval_start;
	logic                      mul_start;
	logic                      advance;
	logic                      read_result;

	logic [CTRL_W-1:0]         ctrl;
	logic [DATA_W-1:0]         imm;
	opcode_t                   op;
	logic [RIDX_W-1:0]         dst;
	logic [RIDX_W-1:0]         src;
	logic                      use_const;
	logic [SHIFT_W-1:0]        sh;
	logic [DATA_W-1:0]         operand_v;
	logic [DATA_W-1:0]         alu_res;

	function automatic logic [DATA_W-1:0] init_value(input logic [RIDX_W-1:0] idx,
			input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] seed);
		logic [DATA_W-1:0] v;
		v = '0;
		if (idx == RIDX_W'(0)) v = key;
		if (idx == RIDX_W'(1)) v = seed;
		return v;
	endfunction

	assign ctrl      = inst_q[DATA_W +: CTRL_W];
	assign imm       = inst_q[DATA_W-1:0];
	assign op        = opcode_t'(ctrl[CTRL_OPC_LSB +: OPC_W]);
	assign dst       = ctrl[CTRL_DEST_LSB +: RIDX_W];
	assign src       = ctrl[CTRL_SRC_LSB +: RIDX_W];
	assign use_const = ctrl[CTRL_CONST_BIT];
	assign sh        = ctrl[CTRL_SHIFT_LSB +: SHIFT_W];
	assign operand_v = use_const ? imm : rdb_q;

	assign pc_inc = pc_q + 1'b1;
	assign last   = (pc_inc == len_q);

	// A shift by the full width yields zero, so a rotate by zero returns the value unchanged.
	always_comb begin
		unique case (op)
			OP_MOV:  alu_res = operand_v;
			OP_ADD:  alu_res = rda_q + operand_v;
			OP_XOR:  alu_res = rda_q ^ operand_v;
			OP_SHL:  alu_res = rda_q << sh;
			OP_SHR:  alu_res = rda_q >> sh;
			OP_ROTL: alu_res = (rda_q << sh) | (rda_q >> (7'(DATA_W) - {1'b0, sh}));
			OP_ROTR: alu_res = (rda_q >> sh) | (rda_q << (7'(DATA_W) - {1'b0, sh}));
			default: alu_res = operand_v;
		endcase
	end

	// The low 64 bits of the product come from three 32x32 partial products.
	always_comb begin
		unique case (mcnt_q)
			2'd0: begin
				mul_a = opa_q[HALF_W-1:0];
				mul_b = opb_q[HALF_W-1:0];
			end
			2'd1: begin
				mul_a = opa_q[HALF_W-1:0];
				mul_b = opb_q[DATA_W-1:HALF_W];
			end
			default: begin
				mul_a = opa_q[DATA_W-1:HALF_W];
				mul_b = opb_q[HALF_W-1:0];
			end
		endcase
	end

	assign mul_res = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		imem_we     = 1'b0;
		rf_we       = 1'b0;
		rf_wdata    = alu_res;
		eval_start  = 1'b0;
		mul_start   = 1'b0;
		advance     = 1'b0;
		read_result = 1'b0;
		done        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					if (head.kind == ITEM_WRITE) begin
						imem_we = 1'b1;
					end else begin
						eval_start = 1'b1;
						state_d    = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_d = (len_q == '0) ? ST_DONE : ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (op == OP_MUL) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end else begin
					rf_we   = 1'b1;
					advance = 1'b1;
					state_d = last ? ST_DONE : ST_DECODE;
				end
			end
			ST_MUL: begin
				if (mcnt_q == 2'd2) state_d = ST_MULWB;
			end
			ST_MULWB: begin
				rf_we    = 1'b1;
				rf_wdata = mul_res;
				advance  = 1'b1;
				state_d  = last ? ST_DONE : ST_DECODE;
			end
			ST_DONE: begin
				read_result = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// While an instruction retires, the next one is already read from the store.
	assign imem_raddr = advance ? pc_inc[IDX_W-1:0] : pc_q[IDX_W-1:0];
	assign rf_addr_a  = read_result ? RIDX_W'(RESULT_REG) : dst;
	assign hash_value = rda_q;

	always_ff @(posedge clk) begin
		if (imem_we) begin
			imem[head.slot] <= {head.ctrl, head.data0};
		end
		inst_q <= imem[imem_raddr];
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[dst] <= rf_wdata;
		end
		rda_q <= rf_valid_q[rf_addr_a] ? rf[rf_addr_a] : init_value(rf_addr_a, key_q, seed_q);
		rdb_q <= rf_valid_q[src] ? rf[src] : init_value(src, key_q, seed_q);
	end

	always_ff @(posedge clk) begin
		if (eval_start) begin
			key_q  <= head.data0;
			seed_q <= head.data1;
			if (32'(prog_len_q) > 32'(PROGRAM_DEPTH)) begin
				len_q <= PC_W'(PROGRAM_DEPTH);
			end else begin
				len_q <= PC_W'(prog_len_q);
			end
		end
		if (mul_start) begin
			opa_q <= rda_q;
			opb_q <= operand_v;
		end
		if (state_q == ST_MUL) begin
			prod_q <= DATA_W'(mul_a) * DATA_W'(mul_b);
			if (mcnt_q == 2'd1) acc_q <= prod_q;
			if (mcnt_q == 2'd2) acc_q <= mul_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prog_len_q <= '0;
			pc_q       <= '0;
			mcnt_q     <= '0;
			rf_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) prog_len_q <= cfg_data;
			if (eval_start) begin
				pc_q <= '0;
			end else if (advance) begin
				pc_q <= pc_inc;
			end
			if (mul_start) begin
				mcnt_q <= '0;
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (eval_start) begin
				rf_valid_q <= '0;
			end else if (rf_we) begin
				rf_valid_q[dst] <= 1'b1;
			end
		end
	end

endmodule

>>> verif/programmable_hash_evaluator_tb.sv
`timescale 1ns / 1ps

module programmable_hash_evaluator_tb;
	import phe_pkg::*;

	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 153;
	localparam int DRAIN_CYCLES    = 16;
	localparam int END_CYCLES      = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam int MAX_REPORTS     = 10;
	// Lengths above the store depth must behave as a full 64-instruction program.
	localparam int LEN_PLAN [NUM_PHASES] = '{1, 3, 64, 5, 2, 127, 9, 4, 65, 16, 7, 6};

	typedef struct packed {
		opcode_t             op;
		logic [REGF_W-1:0]   dest;
		logic                use_imm;
		logic [REGF_W-1:0]   src;
		logic [SHIFT_W-1:0]  shamt;
		logic [DATA_W-1:0]   imm;
	} hash_instr_t;

	typedef struct packed {
		logic                cmd;
		logic [SLOT_W-1:0]   slot;
		hash_instr_t         instr;
		logic [DATA_W-1:0]   key;
		logic [DATA_W-1:0]   seed;
	} hash_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                cmd = CMD_WRITE;
	logic [SLOT_W-1:0]   slot_index = '0;
	logic [OPC_W-1:0]    opcode = '0;
	logic [REGF_W-1:0]   dest_register = '0;
	logic                source_is_constant = 1'b0;
	logic [REGF_W-1:0]   source_register = '0;
	logic [SHIFT_W-1:0]  shift_amount = '0;
	logic [DATA_W-1:0]   immediate_constant = '0;
	logic [DATA_W-1:0]   hash_key = '0;
	logic [DATA_W-1:0]   hash_seed = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LEN_W-1:0]    cfg_data = '0;
	logic                done;
	logic [DATA_W-1:0]   hash_value;

	hash_item_t          pending_items [$];
	logic [DATA_W-1:0]   expected_hashes [$];
	hash_instr_t         program_store [PROGRAM_DEPTH];
	logic [LEN_W-1:0]    program_len_copy = '0;
	hash_item_t          drv_item;
	int                  sender_idle_pct = 0;
	int                  hash_errors = 0;
	int                  stall_cycles = 0;

	programmable_hash_evaluator DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.cmd                (cmd),
		.slot_index         (slot_index),
		.opcode             (opcode),
		.dest_register      (dest_register),
		.source_is_constant (source_is_constant),
		.source_register    (source_register),
		.shift_amount       (shift_amount),
		.immediate_constant (immediate_constant),
		.hash_key           (hash_key),
		.hash_seed          (hash_seed),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.done               (done),
		.hash_value         (hash_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [DATA_W-1:0] rand64();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'd1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic hash_item_t write_item(input int slot, input opcode_t op,
			input int dest, input bit use_imm, input int src, input int shamt,
			input logic [DATA_W-1:0] imm);
		hash_item_t it;
		it.cmd           = CMD_WRITE;
		it.slot          = SLOT_W'(slot);
		it.instr.op      = op;
		it.instr.dest    = REGF_W'(dest);
		it.instr.use_imm = use_imm;
		it.instr.src     = REGF_W'(src);
		it.instr.shamt   = SHIFT_W'(shamt);
		it.instr.imm     = imm;
		it.key           = {$urandom, $urandom};
		it.seed          = {$urandom, $urandom};
		return it;
	endfunction

	function automatic hash_item_t random_write(input int slot);
		int shamt;
		shamt = ($urandom_range(3) == 0) ? 0 :
			(($urandom_range(7) == 0) ? 63 : $urandom_range(63));
		return write_item(slot, opcode_t'($urandom_range(7)), $urandom_range(7),
			1'($urandom_range(1)), $urandom_range(7), shamt, rand64());
	endfunction

	// The instruction fields of an evaluate item are don't-care, so they are randomized.
	function automatic hash_item_t eval_item(input logic [DATA_W-1:0] key,
			input logic [DATA_W-1:0] seed);
		hash_item_t it;
		it      = random_write($urandom_range(PROGRAM_DEPTH - 1));
		it.cmd  = CMD_EVAL;
		it.key  = key;
		it.seed = seed;
		return it;
	endfunction

	// Updates the program copy for a write item, or runs the program for an evaluation.
	function automatic void apply_item(input hash_item_t it);
		logic [DATA_W-1:0] regs [WORK_REGISTERS];
		logic [DATA_W-1:0] operand;
		hash_instr_t ins;
		int n;
		int d;
		int sh;
		if (it.cmd == CMD_WRITE) begin
			program_store[it.slot] = it.instr;
			return;
		end
		foreach (regs[r]) regs[r] = '0;
		regs[0] = it.key;
		regs[1] = it.seed;
		n = (int'(program_len_copy) > PROGRAM_DEPTH) ? PROGRAM_DEPTH : int'(program_len_copy);
		for (int i = 0; i < n; i++) begin
			ins = program_store[i];
			d = int'(ins.dest) % WORK_REGISTERS;
			sh = int'(ins.shamt);
			operand = ins.use_imm ? ins.imm : regs[int'(ins.src) % WORK_REGISTERS];
			case (ins.op)
				OP_MOV:  regs[d] = operand;
				OP_ADD:  regs[d] = regs[d] + operand;
				OP_MUL:  regs[d] = regs[d] * operand;
				OP_XOR:  regs[d] = regs[d] ^ operand;
				OP_SHL:  regs[d] = regs[d] << sh;
				OP_SHR:  regs[d] = regs[d] >> sh;
				OP_ROTL: if (sh != 0) regs[d] = (regs[d] << sh) | (regs[d] >> (64 - sh));
				OP_ROTR: if (sh != 0) regs[d] = (regs[d] >> sh) | (regs[d] << (64 - sh));
			endcase
		end
		expected_hashes.push_back(regs[RESULT_REG]);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) apply_item(drv_item);
			if (!start || !busy) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					drv_item = pending_items.pop_front();
					start              <= 1'b1;
					cmd                <= drv_item.cmd;
					slot_index         <= drv_item.slot;
					opcode             <= drv_item.instr.op;
					dest_register      <= drv_item.instr.dest;
					source_is_constant <= drv_item.instr.use_imm;
					source_register    <= drv_item.instr.src;
					shift_amount       <= drv_item.instr.shamt;
					immediate_constant <= drv_item.instr.imm;
					hash_key           <= drv_item.key;
					hash_seed          <= drv_item.seed;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) program_len_copy = cfg_data;
			if (done) begin
				if (expected_hashes.size() == 0) begin
					hash_errors++;
					if (hash_errors <= MAX_REPORTS)
						$display("unexpected hash_value %h", hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						hash_errors++;
						if (hash_errors <= MAX_REPORTS)
							$display("hash_value mismatch: expected %h, got %h", want, hash_value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("programmable_hash_evaluator regression: fail");
			$finish;
		end
	end

	task automatic write_length(input int len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= LEN_W'(len);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every item is in and every hash is out, then lets queued writes retire.
	// The check runs on the falling edge so that the driver's updates have settled.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || start || expected_hashes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		bit slot_loaded [PROGRAM_DEPTH];
		hash_item_t it;
		int eff_len;
		int nxt;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// An empty program must return zero for any key and seed.
		write_length(0);
		pending_items.push_back(eval_item('1, '1));
		pending_items.push_back(eval_item('0, '0));

		// One instruction of every kind, with register fields that wrap into the working set.
		pending_items.push_back(write_item(0, OP_MOV, 2, 0, 0, 5, rand64()));
		pending_items.push_back(write_item(1, OP_ADD, 7, 1, 3, 0, '1));
		pending_items.push_back(write_item(2, OP_MUL, 2, 0, 6, 0, rand64()));
		pending_items.push_back(write_item(3, OP_XOR, 2, 0, 5, 0, rand64()));
		pending_items.push_back(write_item(4, OP_SHR, 2, 1, 7, 0, '1));
		pending_items.push_back(write_item(5, OP_ROTL, 2, 0, 1, 1, rand64()));
		pending_items.push_back(write_item(6, OP_ROTR, 7, 1, 4, 63, rand64()));
		pending_items.push_back(write_item(7, OP_SHL, 2, 0, 2, 1, rand64()));
		for (int i = 0; i < 8; i++) slot_loaded[i] = 1'b1;
		wait_idle();
		write_length(8);
		pending_items.push_back(eval_item('1, '1));
		pending_items.push_back(eval_item('0, '0));
		pending_items.push_back(eval_item(64'd1, '1));
		pending_items.push_back(eval_item({$urandom, $urandom}, {$urandom, $urandom}));
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			sender_idle_pct = (p < NUM_PHASES / 3) ? 33 : ((p < 2 * NUM_PHASES / 3) ? 55 : 0);
			write_length(LEN_PLAN[p]);
			eff_len = (LEN_PLAN[p] > PROGRAM_DEPTH) ? PROGRAM_DEPTH : LEN_PLAN[p];
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				nxt = 0;
				while (nxt < PROGRAM_DEPTH && slot_loaded[nxt]) nxt++;
				// Never evaluate a program that would run a slot not yet written.
				if (nxt < eff_len)
					it = random_write(nxt);
				else if ($urandom_range(99) < 40)
					it = eval_item(rand64(), rand64());
				else if (eff_len > 0 && $urandom_range(99) < 80)
					it = random_write($urandom_range(eff_len - 1));
				else
					it = random_write($urandom_range(PROGRAM_DEPTH - 1));
				if (it.cmd == CMD_WRITE) slot_loaded[it.slot] = 1'b1;
				pending_items.push_back(it);
			end
			wait_idle();
		end

		repeat (END_CYCLES) @(posedge clk);
		if (hash_errors == 0 && expected_hashes.size() == 0)
			$display("programmable_hash_evaluator regression: pass");
		else
			$display("programmable_hash_evaluator regression: fail");
		$finish;
	end

endmodule
